[design/fraction_reduce_normalize_macros.svh]
// Assertion macros for fraction_reduce_normalize
`ifndef FRACTION_REDUCE_NORMALIZE_MACROS_SVH
`define FRACTION_REDUCE_NORMALIZE_MACROS_SVH

// same-cycle implication, checked outside reset
`define FRN_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define FRN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/frn_pkg.sv]
package frn_pkg;

    localparam int DATA_W = 32;
    localparam int MAG_W  = DATA_W - 1;
    localparam int CNT_W  = $clog2(MAG_W);

    typedef logic [MAG_W-1:0] t_mag;

    typedef struct packed {
        logic signed [DATA_W-1:0] num_in;
        logic signed [DATA_W-1:0] den_in;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] num_out;
        logic [MAG_W-1:0]         den_out;
        logic                     undefined_flag;
    } t_out;

    typedef struct packed {
        logic start;
        t_mag dividend;
        t_mag divisor;
    } t_div_req;

    typedef struct packed {
        logic done;
        t_mag quot;
        t_mag rem;
    } t_div_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GCD,
        S_GCD_WAIT,
        S_DIVN,
        S_DIVN_WAIT,
        S_DIVD,
        S_DIVD_WAIT,
        S_DONE
    } t_state;

    localparam logic signed [DATA_W-1:0] NUM_POS_ONE = DATA_W'(1);
    localparam logic signed [DATA_W-1:0] NUM_NEG_ONE = '1;
    localparam t_mag                     MAG_ONE     = MAG_W'(1);

    // magnitude of a two's complement field, most negative value saturated
    function automatic t_mag f_mag(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] a;
        a = v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
        return a[DATA_W-1] ? '1 : a[MAG_W-1:0];
    endfunction

    // apply sign to a magnitude
    function automatic logic [DATA_W-1:0] f_signed(input t_mag m, input logic neg);
        logic [DATA_W-1:0] e;
        e = {1'b0, m};
        return neg ? (~e + DATA_W'(1)) : e;
    endfunction

endpackage

[design/frn_div.sv]
module frn_div
    import frn_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    t_mag             r_rem;
    t_mag             r_quot;
    t_mag             r_dvs;

    logic [MAG_W:0]   w_trial;
    logic [MAG_W:0]   w_diff;
    logic             w_ge;

    // one quotient bit per cycle, restoring
    always_comb begin
        w_trial = {r_rem, r_quot[MAG_W-1]};
        w_diff  = w_trial - {1'b0, r_dvs};
        w_ge    = (w_trial >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(MAG_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= '0;
            r_quot <= i_req.dividend;
            r_dvs  <= i_req.divisor;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[MAG_W-1:0] : w_trial[MAG_W-1:0];
            r_quot <= {r_quot[MAG_W-2:0], w_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

endmodule

[design/fraction_reduce_normalize.sv]
// fraction_reduce_normalize
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one item: a signed
// numerator and denominator. Output channel (o_out_valid / i_out_ready /
// o_out_data) returns the reduced fraction, sign on the numerator, with
// undefined_flag set for 0/0 (result 0/1).
// One item is in work at a time. A bit-serial restoring divider, one
// quotient bit per cycle, does every modulo of the Euclid loop and the two
// final divisions by the gcd; each use is 31 steps plus start and capture.
// A zero numerator or denominator skips the divider.
// The finished result sits in an output register, so a new item is taken
// as soon as the work is done, even while the receiver stalls; a second
// result then waits in the done state until the output register frees.
// Reset (synchronous, active low) returns to idle and drops o_out_valid.
module fraction_reduce_normalize
    import frn_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

`include "fraction_reduce_normalize_macros.svh"

    t_state   r_state;
    t_state   n_state;

    t_mag     r_na;
    t_mag     r_da;
    t_mag     r_a;
    t_mag     r_b;
    t_mag     r_g;
    t_mag     r_qn;
    logic     r_neg;
    logic     r_sel;
    t_out     r_res;
    logic     r_out_valid;
    t_out     r_out_data;

    t_div_req w_req;
    t_div_rsp w_rsp;
    logic     w_accept;
    logic     w_special;
    logic     w_gcd_end;
    logic     w_out_load;
    t_mag     w_na;
    t_mag     w_da;

    frn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        w_na      = f_mag(i_in_data.num_in);
        w_da      = f_mag(i_in_data.den_in);
        w_accept  = i_in_valid && o_in_ready;
        w_special = (w_na == '0) || (w_da == '0);
        w_gcd_end = (r_a == '0) || (r_b == '0);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = w_special ? S_DONE : S_GCD;
                end
            end
            S_GCD:       n_state = w_gcd_end ? S_DIVN : S_GCD_WAIT;
            S_GCD_WAIT:  n_state = w_rsp.done ? S_GCD : S_GCD_WAIT;
            S_DIVN:      n_state = S_DIVN_WAIT;
            S_DIVN_WAIT: n_state = w_rsp.done ? S_DIVD : S_DIVN_WAIT;
            S_DIVD:      n_state = S_DIVD_WAIT;
            S_DIVD_WAIT: n_state = w_rsp.done ? S_DONE : S_DIVD_WAIT;
            S_DONE:      n_state = (!r_out_valid || i_out_ready) ? S_IDLE : S_DONE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        w_out_load     = 1'b0;
        w_req.start    = 1'b0;
        w_req.dividend = r_na;
        w_req.divisor  = r_g;
        unique case (r_state)
            S_IDLE: o_in_ready = 1'b1;
            S_GCD: begin
                w_req.start    = !w_gcd_end;
                w_req.dividend = (r_a > r_b) ? r_a : r_b;
                w_req.divisor  = (r_a > r_b) ? r_b : r_a;
            end
            S_DIVN: w_req.start = 1'b1;
            S_DIVD: begin
                w_req.start    = 1'b1;
                w_req.dividend = r_da;
            end
            S_DONE: w_out_load = !r_out_valid || i_out_ready;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_na  <= w_na;
            r_da  <= w_da;
            r_a   <= w_na;
            r_b   <= w_da;
            r_neg <= i_in_data.num_in[DATA_W-1] ^ i_in_data.den_in[DATA_W-1];
            if (w_na == '0) begin
                r_res.num_out        <= '0;
                r_res.den_out        <= MAG_ONE;
                r_res.undefined_flag <= (w_da == '0);
            end else begin
                r_res.num_out        <= i_in_data.num_in[DATA_W-1] ? NUM_NEG_ONE : NUM_POS_ONE;
                r_res.den_out        <= '0;
                r_res.undefined_flag <= 1'b0;
            end
        end
        if (r_state == S_GCD) begin
            r_sel <= (r_a > r_b);
            if (w_gcd_end) begin
                r_g <= r_a | r_b;
            end
        end
        if ((r_state == S_GCD_WAIT) && w_rsp.done) begin
            if (r_sel) begin
                r_a <= w_rsp.rem;
            end else begin
                r_b <= w_rsp.rem;
            end
        end
        if ((r_state == S_DIVN_WAIT) && w_rsp.done) begin
            r_qn <= w_rsp.quot;
        end
        if ((r_state == S_DIVD_WAIT) && w_rsp.done) begin
            r_res.num_out        <= f_signed(r_qn, r_neg);
            r_res.den_out        <= w_rsp.quot;
            r_res.undefined_flag <= 1'b0;
        end
        if (w_out_load) begin
            r_out_data <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `FRN_ASSERT_NOW(a_undef_is_zero_over_one,
        o_out_valid && o_out_data.undefined_flag,
        (o_out_data.num_out == '0) && (o_out_data.den_out == MAG_ONE),
        "undefined result is not 0/1")
    `FRN_ASSERT_NOW(a_zero_den_unit_num,
        o_out_valid && (o_out_data.den_out == '0),
        (o_out_data.num_out == NUM_POS_ONE) || (o_out_data.num_out == NUM_NEG_ONE),
        "zero denominator without unit numerator")
    `FRN_ASSERT_NOW(a_div_done_in_wait,
        w_rsp.done,
        (r_state == S_GCD_WAIT) || (r_state == S_DIVN_WAIT) || (r_state == S_DIVD_WAIT),
        "divider finished outside a wait state")
    `FRN_ASSERT_NEXT(a_one_item_in_work,
        i_in_valid && o_in_ready,
        !o_in_ready,
        "second item taken while one is in work")

endmodule

[test/fraction_checker.sv]
module fraction_checker
    import frn_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  t_out i_out_data,
    output int   o_mismatches,
    output int   o_pending
);

    t_out expected_fractions[$];
    int   mismatch_count = 0;

    assign o_mismatches = mismatch_count;
    assign o_pending    = expected_fractions.size();

    // saturated magnitude of a two's complement field
    function automatic logic [DATA_W-1:0] magnitude_of(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] a;
        a = v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
        if (a[DATA_W-1]) begin
            a = {1'b0, {MAG_W{1'b1}}};
        end
        return a;
    endfunction

    function automatic t_out reduce_fraction(input t_in item);
        t_out              res;
        logic              nneg;
        logic              dneg;
        logic [DATA_W-1:0] na;
        logic [DATA_W-1:0] da;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] g;
        logic [DATA_W-1:0] rn;
        logic [DATA_W-1:0] rd;
        nneg = item.num_in[DATA_W-1];
        dneg = item.den_in[DATA_W-1];
        na   = magnitude_of(item.num_in);
        da   = magnitude_of(item.den_in);
        res.undefined_flag = 1'b0;
        if (na == '0) begin
            res.num_out        = '0;
            res.den_out        = MAG_ONE;
            res.undefined_flag = (da == '0);
        end else if (da == '0) begin
            res.num_out = nneg ? NUM_NEG_ONE : NUM_POS_ONE;
            res.den_out = '0;
        end else begin
            a = na;
            b = da;
            while (a != '0 && b != '0) begin
                if (a > b) begin
                    a = a % b;
                end else begin
                    b = b % a;
                end
            end
            g  = a + b;
            rn = na / g;
            rd = da / g;
            res.num_out = (nneg ^ dneg) ? (~rn + DATA_W'(1)) : rn;
            res.den_out = rd[MAG_W-1:0];
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out exp_res;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                expected_fractions.push_back(reduce_fraction(i_in_data));
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_fractions.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("unexpected result %0d/%0d flag %0b",
                                 i_out_data.num_out, i_out_data.den_out,
                                 i_out_data.undefined_flag);
                    end
                end else begin
                    exp_res = expected_fractions.pop_front();
                    if (i_out_data.num_out !== exp_res.num_out ||
                        i_out_data.den_out !== exp_res.den_out ||
                        i_out_data.undefined_flag !== exp_res.undefined_flag) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("mismatch: expected %0d/%0d flag %0b, got %0d/%0d flag %0b",
                                     exp_res.num_out, exp_res.den_out,
                                     exp_res.undefined_flag,
                                     i_out_data.num_out, i_out_data.den_out,
                                     i_out_data.undefined_flag);
                        end
                    end
                end
            end
        end
    end

endmodule

[test/testbench.sv]
module testbench;
    import frn_pkg::*;

    localparam int RANDOM_ITEMS = 1250;
    localparam int CYCLE_LIMIT  = 7000000;
    localparam logic signed [DATA_W-1:0] MAX_POS  = {1'b0, {MAG_W{1'b1}}};
    localparam logic signed [DATA_W-1:0] MOST_NEG = {1'b1, {MAG_W{1'b0}}};

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in  i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;
    int   mismatches;
    int   pending;
    int   cycle_count = 0;
    int   burst_left = 0;

    fraction_reduce_normalize dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    fraction_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_data  (o_out_data),
        .o_mismatches(mismatches),
        .o_pending   (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(16, 80);
    endfunction

    // called at a falling edge; leaves valid high after the item is taken
    task automatic send_item(input logic [DATA_W-1:0] n, input logic [DATA_W-1:0] d);
        int gap;
        if (burst_left > 0) begin
            gap = 0;
            burst_left--;
        end else begin
            gap = idle_length();
            if ($urandom_range(0, 99) < 3) begin
                burst_left = $urandom_range(10, 40);
            end
        end
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid       = 1'b1;
        i_in_data.num_in = n;
        i_in_data.den_in = d;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    function automatic logic [DATA_W-1:0] special_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return MOST_NEG;
            2: return MAX_POS;
            3: return DATA_W'(1);
            4: return '1;
            default: return $urandom;
        endcase
    endfunction

    // receiver: windows with stalls and windows without
    initial begin
        int  stall_left;
        int  window_left;
        bit  stalls_on;
        stall_left  = 0;
        window_left = 0;
        stalls_on   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (window_left == 0) begin
                stalls_on   = ($urandom_range(0, 3) != 0);
                window_left = $urandom_range(200, 2000);
            end
            window_left--;
            if (stall_left > 0) begin
                i_out_ready = 1'b0;
                stall_left--;
            end else begin
                i_out_ready = 1'b1;
                if (stalls_on && $urandom_range(0, 99) < 15) begin
                    stall_left = idle_length() + 1;
                end
            end
        end
    end

    initial begin
        int          r;
        int          g;
        logic [DATA_W-1:0] n;
        logic [DATA_W-1:0] d;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_item(0, 0);
        send_item(0, 5);
        send_item(0, -5);
        send_item(7, 0);
        send_item(-7, 0);
        send_item(MAX_POS, MAX_POS);
        send_item(-MAX_POS, MAX_POS);
        send_item(MAX_POS, MAX_POS - 1);
        send_item(MOST_NEG, 1);
        send_item(1, MOST_NEG);
        send_item(MOST_NEG, MOST_NEG);
        send_item(MOST_NEG, 0);
        send_item(0, MOST_NEG);
        send_item(MOST_NEG, MAX_POS);
        send_item(6, 4);
        send_item(-6, 4);
        send_item(6, -4);
        send_item(-6, -4);
        send_item(1, 1);
        send_item(-1, -1);
        send_item(1836311903, 1134903170);
        send_item(-1134903170, 1836311903);
        send_item(32'h4000_0000, 32'h6000_0000);
        send_item(12, 3);
        send_item(3, -12);
        wait_drained();

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == RANDOM_ITEMS / 2) begin
                wait_drained();
            end
            r = $urandom_range(0, 99);
            if (r < 35) begin
                n = $urandom;
                d = $urandom;
            end else if (r < 65) begin
                g = $urandom_range(1, 40000);
                n = g * (int'($urandom_range(0, 2000)) - 1000);
                d = g * (int'($urandom_range(0, 2000)) - 1000);
            end else if (r < 90) begin
                n = int'($urandom_range(0, 131070)) - 65535;
                d = int'($urandom_range(0, 131070)) - 65535;
            end else begin
                n = special_word();
                d = special_word();
            end
            send_item(n, d);
        end
        i_in_valid = 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/frn_pkg.sv
design/frn_div.sv
design/fraction_reduce_normalize.sv
test/fraction_checker.sv
test/testbench.sv
